// ===== sv/gkps_pkg.sv =====
// ----------------------------------------------------------------------------
// gkps_pkg
// Shared types, widths and the exponent fraction table for the Gaussian
// kernel pair sum unit.
// ----------------------------------------------------------------------------
package gkps_pkg;

    localparam int COORD_W  = 16;
    localparam int CNT_W    = 13;
    localparam int CFG_W    = 16;
    localparam int DIST_W   = 40;
    localparam int WEIGHT_W = 48;
    localparam int PROD_W   = 24;
    localparam int REG_COUNT = 2;
    localparam int CFG_IDX_W = 1;

    // Fraction table of 2^-f, one entry per step of 1/EXP_DEPTH.
    localparam int EXP_DEPTH = 256;
    localparam int EXP_IDX_W = 8;

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_RADIUS  = 1'd1;

    // What the back end does with a closed point pair.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REP,
        OP_MEM
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic                far;
        logic                last;
        logic [DIST_W-1:0]   d2;
        logic [PROD_W-1:0]   mult;
    } t_job;

    typedef logic [15:0] t_exp_table [EXP_DEPTH];

    // Long division by shift and subtract, used while building the table.
    function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry k is 2^-(k/EXP_DEPTH) in Q1.15, built from a series for exp and
    // rounded half up. Evaluated at elaboration only.
    function automatic t_exp_table build_exp_table();
        t_exp_table  tab;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            t    = (64'(k) * LN2_Q32) >> EXP_IDX_W;
            sum  = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            done = 1'b0;
            for (int n = 1; n <= 24; n++) begin
                if (!done) begin
                    term = const_div((term * t) >> 32, 64'(n));
                    if (term == 64'd0) begin
                        done = 1'b1;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            tab[k] = 16'(const_div(64'h0000_8000_0000_0000 + (sum >> 1), sum));
        end
        return tab;
    endfunction

endpackage

// ===== sv/gkps_queue.sv =====
// ----------------------------------------------------------------------------
// gkps_queue
// Two-entry queue of closed point pairs between the front and back ends.
// ----------------------------------------------------------------------------
module gkps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gkps_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output gkps_pkg::t_job o_job
);
    import gkps_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/gkps_front.sv =====
// ----------------------------------------------------------------------------
// gkps_front
// Accepts coordinate transactions, sums squared differences, makes the far
// test and hands each closed point pair to the queue.
// ----------------------------------------------------------------------------
module gkps_front #(
    parameter int MAX_MEMBERS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic signed [gkps_pkg::COORD_W-1:0] i_coord_a,
    input  logic signed [gkps_pkg::COORD_W-1:0] i_coord_b,
    input  logic                          i_last_coord,
    input  logic                          i_last_pair,
    input  logic [gkps_pkg::CNT_W-1:0]    i_count_a,
    input  logic [gkps_pkg::CNT_W-1:0]    i_count_b,
    input  logic [gkps_pkg::CFG_W-1:0]    i_far_radius,
    input  logic                          i_full,
    output logic                          o_push,
    output gkps_pkg::t_job                o_job
);
    import gkps_pkg::*;

    localparam logic [16:0] MAX_CNT = 17'(MAX_MEMBERS);

    logic [DIST_W-1:0] r_dist;
    logic              r_far;

    logic [31:0]        far_sq;
    logic signed [16:0] diff;
    logic [15:0]        mag;
    logic [31:0]        sq;
    logic [16:0]        ca;
    logic [16:0]        cb;
    logic [33:0]        prod;
    logic [PROD_W-1:0]  cp_new;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  dist_next;
    logic               accept;
    logic               active;
    logic               close;
    logic               far_test;

    always_comb begin
        far_sq = 32'(i_far_radius) * 32'(i_far_radius);
        diff   = 17'(i_coord_a) - 17'(i_coord_b);
        mag    = diff[16] ? 16'(-diff) : diff[15:0];
        sq     = 32'(mag) * 32'(mag);
        ca     = (17'(i_count_a) > MAX_CNT) ? MAX_CNT : 17'(i_count_a);
        cb     = (17'(i_count_b) > MAX_CNT) ? MAX_CNT : 17'(i_count_b);
        prod   = 34'(ca) * 34'(cb);
        cp_new = (prod > 34'hFF_FFFF) ? '1 : prod[PROD_W-1:0];
        sum    = {1'b0, r_dist} + (DIST_W+1)'(sq);
        dist_next = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
        accept = i_valid && !i_full;
        active = !i_kind || !r_far;
        close  = i_last_coord || i_last_pair;
        // Distance above four radii, compared on the squares.
        far_test = dist_next > DIST_W'({far_sq, 4'b0000});
    end

    assign o_ready = !i_full;
    assign o_push  = accept && ((active && close) || i_last_pair);

    always_comb begin
        o_job.op   = (active && close) ? (i_kind ? OP_MEM : OP_REP) : OP_NONE;
        o_job.far  = (active && close && !i_kind) ? far_test : r_far;
        o_job.last = i_last_pair;
        o_job.d2   = dist_next;
        o_job.mult = i_kind ? PROD_W'(1) : cp_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_far  <= 1'b0;
        end else if (accept) begin
            if (i_last_pair) begin
                r_dist <= '0;
                r_far  <= 1'b0;
            end else begin
                if (active) begin
                    r_dist <= close ? '0 : dist_next;
                    if (close && !i_kind) begin
                        r_far <= far_test;
                    end
                end
            end
        end
    end

endmodule

// ===== sv/gkps_back.sv =====
// ----------------------------------------------------------------------------
// gkps_back
// Evaluates the kernel term of each queued point pair step by step and keeps
// the group weight until the result transaction is taken.
// ----------------------------------------------------------------------------
module gkps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  gkps_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [gkps_pkg::CFG_W-1:0]    i_sigma,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gkps_pkg::WEIGHT_W-1:0] o_weight,
    output logic                          o_used_approx
);
    import gkps_pkg::*;

    localparam t_exp_table EXP_TABLE = build_exp_table();

    typedef enum logic [3:0] {
        ST_IDLE, ST_X0, ST_X1, ST_Y0, ST_Y1, ST_TAB, ST_SHIFT, ST_ACC, ST_OUT
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [55:0]         r_p;
    logic                r_zero;
    logic [58:0]         r_y;
    logic [39:0]         r_v;
    logic [6:0]          r_n;
    logic [WEIGHT_W-1:0] r_term;
    logic [WEIGHT_W-1:0] r_weight;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic                r_out_far;

    logic [56:0]          x;
    logic [34:0]          y;
    logic [48:0]          shifted;
    logic [WEIGHT_W:0]    acc_sum;
    logic [WEIGHT_W-1:0]  weight_new;

    always_comb begin
        x       = {r_p, 1'b0};
        y       = r_y[58:24];
        shifted = {r_v, 9'b0} >> r_n[5:0];
        acc_sum = {1'b0, r_weight} + {1'b0, r_term};
        case (r_job.op)
            OP_REP:  weight_new = r_term;
            OP_MEM:  weight_new = acc_sum[WEIGHT_W] ? '1 : acc_sum[WEIGHT_W-1:0];
            default: weight_new = r_weight;
        endcase
    end

    assign o_pop         = (r_state == ST_IDLE) && !i_empty;
    assign o_valid       = (r_state == ST_OUT);
    assign o_weight      = r_out_weight;
    assign o_used_approx = r_out_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_weight <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job  <= i_job;
                        r_term <= '0;
                        if (i_job.op == OP_MEM || (i_job.op == OP_REP && i_job.far)) begin
                            r_state <= ST_X0;
                        end else begin
                            r_state <= ST_ACC;
                        end
                    end
                end
                ST_X0: begin
                    r_p     <= 56'(i_sigma) * 56'(r_job.d2[19:0]);
                    r_state <= ST_X1;
                end
                ST_X1: begin
                    r_p     <= r_p + ((56'(i_sigma) * 56'(r_job.d2[39:20])) << 20);
                    r_state <= ST_Y0;
                end
                ST_Y0: begin
                    r_zero  <= (x[56:34] != '0);
                    r_y     <= 59'(x[16:0]) * 59'(LOG2E_Q24);
                    r_state <= ST_Y1;
                end
                ST_Y1: begin
                    r_y     <= r_y + ((59'(x[33:17]) * 59'(LOG2E_Q24)) << 17);
                    r_state <= ST_TAB;
                end
                ST_TAB: begin
                    r_n     <= y[34:28];
                    r_v     <= 40'(r_job.mult) * 40'(EXP_TABLE[y[27:28-EXP_IDX_W]]);
                    r_state <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    r_term  <= (r_zero || r_n[6]) ? '0 : shifted[WEIGHT_W-1:0];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_job.last) begin
                        r_out_weight <= weight_new;
                        r_out_far    <= r_job.far;
                        r_weight     <= '0;
                        r_state      <= ST_OUT;
                    end else begin
                        r_weight <= weight_new;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/gaussian_kernel_pair_sum_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_kernel_pair_sum_unit
// Gaussian-kernel weight between two groups of points, one coordinate per
// input transaction, one weight per group pair.
// ----------------------------------------------------------------------------
// The unit takes one coordinate transaction per clock cycle while its queue
// has room. The front end folds each transaction into the running squared
// distance in that cycle; every closed point pair (last_coord or last_pair)
// becomes one entry in a two-entry queue, except a member pair closed by
// last_coord alone after the group was found far. The back end takes a pair
// that needs a kernel term through the pop, sigma times distance, the
// base-2 conversion, one table read with its multiply, one shift and one
// accumulate, and a pair that needs none through the pop and the accumulate
// alone. A result transaction is held in the output register until it is
// taken; the front end keeps accepting meanwhile until the queue fills.
// Configuration writes take effect at once for both sigma and the far
// radius, and must be made while the unit is idle. The fraction table is a
// constant and needs no clearing after reset.
// ----------------------------------------------------------------------------
module gaussian_kernel_pair_sum_unit #(
    parameter int MAX_MEMBERS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [gkps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gkps_pkg::CFG_W-1:0]        i_cfg_data,
    // Coordinate transactions.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic signed [gkps_pkg::COORD_W-1:0] i_coord_a,
    input  logic signed [gkps_pkg::COORD_W-1:0] i_coord_b,
    input  logic                              i_last_coord,
    input  logic                              i_last_pair,
    input  logic [gkps_pkg::CNT_W-1:0]        i_count_a,
    input  logic [gkps_pkg::CNT_W-1:0]        i_count_b,
    // Result transactions.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [gkps_pkg::WEIGHT_W-1:0]     o_weight,
    output logic                              o_used_approx
);
    import gkps_pkg::*;

    logic [CFG_W-1:0] r_sigma;
    logic [CFG_W-1:0] r_far_radius;

    t_job q_in_job;
    t_job q_out_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Register file: sigma in Q4.12, far radius in Q8.8.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma      <= 16'd4096;
            r_far_radius <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIGMA_SCALE: r_sigma      <= i_cfg_data;
                REG_FAR_RADIUS:  r_far_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gkps_front #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_coord_a    (i_coord_a),
        .i_coord_b    (i_coord_b),
        .i_last_coord (i_last_coord),
        .i_last_pair  (i_last_pair),
        .i_count_a    (i_count_a),
        .i_count_b    (i_count_b),
        .i_far_radius (r_far_radius),
        .i_full       (full),
        .o_push       (push),
        .o_job        (q_in_job)
    );

    // The queue lets the front end keep streaming coordinates while the back
    // end works through a kernel term or waits on the result transaction.
    gkps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (q_in_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (q_out_job)
    );

    gkps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (q_out_job),
        .o_pop         (pop),
        .i_sigma       (r_sigma),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_weight      (o_weight),
        .o_used_approx (o_used_approx)
    );

endmodule

// ===== sv/gkps_checker.sv =====
// ----------------------------------------------------------------------------
// gkps_checker
// Port-level checks for the Gaussian kernel pair sum unit.
// ----------------------------------------------------------------------------
module gkps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [gkps_pkg::WEIGHT_W-1:0]     o_weight,
    input logic                              o_used_approx
);

    // Reset empties the queue and drops the result valid.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_ready && !o_valid)
        else $error("queue not empty or result shown after reset");

    // No result is shown directly after reset.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result shown directly after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result transaction dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_weight) && $stable(o_used_approx))
        else $error("result payload changed while stalled");

endmodule

bind gaussian_kernel_pair_sum_unit gkps_checker u_gkps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_weight      (o_weight),
    .o_used_approx (o_used_approx)
);
